// ===== rtl/lsmt_pkg.sv =====
// Shared types and constants for the LCD scanline mode timing block.
package lsmt_pkg;

   // Display modes as reported on the result channel.
   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_OAM    = 2'd2;
   localparam logic [1:0] MODE_DRAW   = 2'd3;

   // Mode lengths in dots and the special lines.
   localparam logic [9:0] DOTS_OAM    = 10'd80;
   localparam logic [9:0] DOTS_DRAW   = 10'd172;
   localparam logic [9:0] DOTS_HBLANK = 10'd204;
   localparam logic [9:0] DOTS_LINE   = 10'd456;
   localparam logic [7:0] LINE_VBLANK = 8'd144;
   localparam logic [7:0] LINE_LAST   = 8'd153;

   // Status interrupt select bits.
   localparam int SEL_LYC    = 6;
   localparam int SEL_HBLANK = 3;
   localparam int SEL_VBLANK = 4;
   localparam int SEL_OAM    = 5;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_DISPLAY_ON  = 3'd0;
   localparam logic [2:0] REG_WINDOW_ON   = 3'd1;
   localparam logic [2:0] REG_STAT_SELECT = 3'd2;
   localparam logic [2:0] REG_LINE_CMP    = 3'd3;
   localparam logic [2:0] REG_WINDOW_TOP  = 3'd4;

   localparam int ADDR_WIDTH = 5;
   localparam int DATA_WIDTH = 32;

   // Configuration as seen by the timing core.
   typedef struct packed {
      logic       display_on;
      logic       window_on;
      logic [7:0] status_irq_select;
      logic [7:0] line_compare;
      logic [7:0] window_top_line;
   } cfg_type;

   // One result word.
   typedef struct packed {
      logic [1:0] ppu_mode;
      logic [7:0] line_number;
      logic       vblank_irq;
      logic       stat_irq;
      logic       frame_ready;
      logic       line_done;
      logic       window_live;
      logic [7:0] window_line;
   } rsp_word_type;

endpackage

// ===== rtl/lsmt_if.sv =====
// Handshake interfaces for the input and result channels.
interface lsmt_req_if;
   logic       valid;
   logic       ready;
   logic [6:0] cycles_elapsed;

   modport source (output valid, output cycles_elapsed, input ready);
   modport sink   (input valid, input cycles_elapsed, output ready);
endinterface

interface lsmt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] ppu_mode;
   logic [7:0] line_number;
   logic       vblank_irq;
   logic       stat_irq;
   logic       frame_ready;
   logic       line_done;
   logic       window_live;
   logic [7:0] window_line;

   modport source (output valid, output ppu_mode, output line_number, output vblank_irq,
                   output stat_irq, output frame_ready, output line_done,
                   output window_live, output window_line, input ready);
   modport sink   (input valid, input ppu_mode, input line_number, input vblank_irq,
                   input stat_irq, input frame_ready, input line_done,
                   input window_live, input window_line, output ready);
endinterface

// ===== rtl/lsmt_csr.sv =====
// APB-style configuration registers of the scanline timing block.
module lsmt_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lsmt_pkg::ADDR_WIDTH-1:0]   paddr,
   input  logic [lsmt_pkg::DATA_WIDTH-1:0]   pwdata,
   output logic [lsmt_pkg::DATA_WIDTH-1:0]   prdata,
   output logic                              pready,
   output lsmt_pkg::cfg_type                 cfg
);

   lsmt_pkg::cfg_type cfg_ff;
   lsmt_pkg::cfg_type cfg_in;
   logic [2:0]        reg_index;
   logic              write_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign write_en  = psel & penable & pwrite;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            lsmt_pkg::REG_DISPLAY_ON:  cfg_in.display_on        = pwdata[0];
            lsmt_pkg::REG_WINDOW_ON:   cfg_in.window_on         = pwdata[0];
            lsmt_pkg::REG_STAT_SELECT: cfg_in.status_irq_select = pwdata[7:0];
            lsmt_pkg::REG_LINE_CMP:    cfg_in.line_compare      = pwdata[7:0];
            lsmt_pkg::REG_WINDOW_TOP:  cfg_in.window_top_line   = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data mux.
   always_comb begin
      prdata = '0;
      unique case (reg_index)
         lsmt_pkg::REG_DISPLAY_ON:  prdata[0]   = cfg_ff.display_on;
         lsmt_pkg::REG_WINDOW_ON:   prdata[0]   = cfg_ff.window_on;
         lsmt_pkg::REG_STAT_SELECT: prdata[7:0] = cfg_ff.status_irq_select;
         lsmt_pkg::REG_LINE_CMP:    prdata[7:0] = cfg_ff.line_compare;
         lsmt_pkg::REG_WINDOW_TOP:  prdata[7:0] = cfg_ff.window_top_line;
         default: ;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/lsmt_core.sv =====
// Timing state and the one-step mode transition logic.
module lsmt_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [6:0]             cycles_elapsed,
   input  lsmt_pkg::cfg_type      cfg,
   output lsmt_pkg::rsp_word_type word
);

   logic [9:0] dot_ff,  dot_in;
   logic [1:0] mode_ff, mode_in;
   logic [7:0] line_ff, line_in;
   logic       win_flag_ff, win_flag_in;
   logic [7:0] win_count_ff, win_count_in;

   logic [9:0] dot_sum;
   logic [7:0] line_inc;
   logic       lyc_hit;
   logic       vblank_irq, stat_irq, frame_ready, line_done;

   assign dot_sum  = dot_ff + {3'b000, cycles_elapsed};
   assign line_inc = line_ff + 8'd1;
   assign lyc_hit  = cfg.status_irq_select[lsmt_pkg::SEL_LYC];

   // Next state: at most one mode move per word.
   always_comb begin
      dot_in       = dot_ff;
      mode_in      = mode_ff;
      line_in      = line_ff;
      win_flag_in  = win_flag_ff;
      win_count_in = win_count_ff;
      vblank_irq   = 1'b0;
      stat_irq     = 1'b0;
      frame_ready  = 1'b0;
      line_done    = 1'b0;
      if (cfg.display_on) begin
         dot_in = dot_sum;
         unique case (mode_ff)
            lsmt_pkg::MODE_HBLANK: begin
               if (dot_sum >= lsmt_pkg::DOTS_HBLANK) begin
                  dot_in  = dot_sum - lsmt_pkg::DOTS_HBLANK;
                  line_in = line_inc;
                  if (line_inc == lsmt_pkg::LINE_VBLANK) begin
                     mode_in     = lsmt_pkg::MODE_VBLANK;
                     vblank_irq  = 1'b1;
                     frame_ready = 1'b1;
                     stat_irq    = (lyc_hit && line_inc == cfg.line_compare) ||
                                   cfg.status_irq_select[lsmt_pkg::SEL_VBLANK];
                  end else begin
                     mode_in  = lsmt_pkg::MODE_OAM;
                     stat_irq = (lyc_hit && line_inc == cfg.line_compare) ||
                                cfg.status_irq_select[lsmt_pkg::SEL_OAM];
                     if (cfg.window_on && cfg.window_top_line == line_inc) begin
                        win_flag_in = 1'b1;
                     end
                  end
               end
            end
            lsmt_pkg::MODE_VBLANK: begin
               if (dot_sum >= lsmt_pkg::DOTS_LINE) begin
                  dot_in  = dot_sum - lsmt_pkg::DOTS_LINE;
                  line_in = line_inc;
                  // Past the last line the frame wraps to line zero.
                  if (line_inc > lsmt_pkg::LINE_LAST) begin
                     line_in      = '0;
                     win_count_in = '0;
                     mode_in      = lsmt_pkg::MODE_OAM;
                     stat_irq     = (lyc_hit && cfg.line_compare == 8'd0) ||
                                    cfg.status_irq_select[lsmt_pkg::SEL_OAM];
                     win_flag_in  = cfg.window_on && cfg.window_top_line == 8'd0;
                  end
               end
            end
            lsmt_pkg::MODE_OAM: begin
               if (dot_sum >= lsmt_pkg::DOTS_OAM) begin
                  dot_in  = dot_sum - lsmt_pkg::DOTS_OAM;
                  mode_in = lsmt_pkg::MODE_DRAW;
               end
            end
            lsmt_pkg::MODE_DRAW: begin
               if (dot_sum >= lsmt_pkg::DOTS_DRAW) begin
                  dot_in    = dot_sum - lsmt_pkg::DOTS_DRAW;
                  mode_in   = lsmt_pkg::MODE_HBLANK;
                  line_done = 1'b1;
                  stat_irq  = cfg.status_irq_select[lsmt_pkg::SEL_HBLANK];
                  if (win_flag_ff) begin
                     win_count_in = win_count_ff + 8'd1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // State registers advance once per word.
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff       <= '0;
         mode_ff      <= lsmt_pkg::MODE_DRAW;
         line_ff      <= '0;
         win_flag_ff  <= 1'b0;
         win_count_ff <= '0;
      end else if (step_en) begin
         dot_ff       <= dot_in;
         mode_ff      <= mode_in;
         line_ff      <= line_in;
         win_flag_ff  <= win_flag_in;
         win_count_ff <= win_count_in;
      end
   end

   // Result word reports the state after this step.
   always_comb begin
      word.ppu_mode    = mode_in;
      word.line_number = line_in;
      word.vblank_irq  = vblank_irq;
      word.stat_irq    = stat_irq;
      word.frame_ready = frame_ready;
      word.line_done   = line_done;
      word.window_live = win_flag_in;
      word.window_line = win_count_in;
   end

endmodule

// ===== rtl/lcd_scanline_mode_timing_top.sv =====
// Top level of the LCD scanline mode timing block.
// Each input word carries the dot cycles elapsed since the previous one; the block answers
// every word with exactly one result word holding the mode, line, interrupt pulses and
// window tracking after that step. One word is taken per clock unless the result register is
// held full: the word is captured in an input register, the step logic sits between it and
// the result register, and a result is offered once its step is loaded into the result register.
// The input side keeps accepting while a result waits, as long as the input register is empty
// or the result register will free up at the same edge. Configuration
// writes go through the APB-style port, one register per word address, and are meant to be
// made while no word is in flight. With the display off a word changes nothing and returns
// the current state with all pulses low.
module lcd_scanline_mode_timing_top (
   input  logic                              clock,
   input  logic                              reset,
   lsmt_req_if.sink                          req,
   lsmt_rsp_if.source                        rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lsmt_pkg::ADDR_WIDTH-1:0]   paddr,
   input  logic [lsmt_pkg::DATA_WIDTH-1:0]   pwdata,
   output logic [lsmt_pkg::DATA_WIDTH-1:0]   prdata,
   output logic                              pready
);

   lsmt_pkg::cfg_type      cfg;
   lsmt_pkg::rsp_word_type step_word;
   lsmt_pkg::rsp_word_type rsp_word_ff;

   logic       req_valid_ff;
   logic [6:0] req_cycles_ff;
   logic       rsp_valid_ff;
   logic       advance;

   // The stage moves when the result register is free or being emptied.
   assign advance   = ~rsp_valid_ff | rsp.ready;
   assign req.ready = ~req_valid_ff | advance;

   lsmt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lsmt_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step_en        (req_valid_ff & advance),
      .cycles_elapsed (req_cycles_ff),
      .cfg            (cfg),
      .word           (step_word)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req.ready) begin
         req_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         req_cycles_ff <= req.cycles_elapsed;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid_ff) begin
         rsp_word_ff <= step_word;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.ppu_mode    = rsp_word_ff.ppu_mode;
   assign rsp.line_number = rsp_word_ff.line_number;
   assign rsp.vblank_irq  = rsp_word_ff.vblank_irq;
   assign rsp.stat_irq    = rsp_word_ff.stat_irq;
   assign rsp.frame_ready = rsp_word_ff.frame_ready;
   assign rsp.line_done   = rsp_word_ff.line_done;
   assign rsp.window_live = rsp_word_ff.window_live;
   assign rsp.window_line = rsp_word_ff.window_line;

   // Entering vertical blank always lands on the first blank line.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.vblank_irq |->
         rsp_word_ff.ppu_mode == lsmt_pkg::MODE_VBLANK &&
         rsp_word_ff.line_number == lsmt_pkg::LINE_VBLANK)
      else $error("vblank pulse outside vblank entry");

   // The end of drawing always moves to horizontal blank.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.line_done |->
         rsp_word_ff.ppu_mode == lsmt_pkg::MODE_HBLANK)
      else $error("line done pulse without horizontal blank");

   // The line counter never runs past the last blank line.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_word_ff.line_number <= lsmt_pkg::LINE_LAST)
      else $error("line number out of range");

   // Frame ready and vblank pulses travel together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_word_ff.frame_ready == rsp_word_ff.vblank_irq)
      else $error("frame ready and vblank pulses disagree");

endmodule
